### hdl/assert_macros.svh
// Assertion macros for the port-level checker file of the grid solver.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define ASSERT_IMPL(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("checker assertion failed");

// Next-cycle implication, disabled while dis is high.
`define ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("checker assertion failed");

`endif

### hdl/fdtd_pkg.sv
// Package of the 2D TM field solver: grid size, field and beat types, codes,
// and the cell address and saturating half-update functions. No dependencies.
package fdtd_pkg;

  localparam int GRID_X = 8;
  localparam int GRID_Y = 8;
  localparam int CELLS  = GRID_X * GRID_Y;
  localparam int XW     = $clog2(GRID_X + 1);
  localparam int YW     = $clog2(GRID_Y);
  localparam int AW     = $clog2(CELLS);

  typedef logic signed [23:0] field_t;
  typedef logic signed [25:0] sum_t;
  typedef logic signed [26:0] wide_t;

  localparam field_t FIELD_MAX = 24'sh7FFFFF;
  localparam field_t FIELD_MIN = 24'sh800000;

  typedef struct packed {
    field_t ez;
    field_t hx;
    field_t hy;
  } cell_t;

  typedef struct packed {
    logic       cmd;
    logic [2:0] cell_x;
    logic [2:0] cell_y;
  } req_t;

  typedef struct packed {
    field_t      ez_value;
    field_t      hx_value;
    field_t      hy_value;
    logic [31:0] steps_taken;
  } rsp_t;

  typedef struct packed {
    logic h_phase;
    logic ez_upd;
    logic src_hit;
    logic hx_upd;
    logic hy_upd;
  } calc_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EZ,
    ST_H,
    ST_READ,
    ST_RDOUT,
    ST_STEPOUT
  } state_t;

  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_X     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_Y     = 2'd2;

  localparam field_t     SOURCE_LEVEL_RST = 24'sd65536;
  localparam logic [2:0] SOURCE_X_RST     = 3'd4;
  localparam logic [2:0] SOURCE_Y_RST     = 3'd4;

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                              input logic [YW-1:0] y);
    cell_addr = AW'(int'(y) * GRID_X + int'(x));
  endfunction

  // Old value plus floor(sum / 2), saturated to the field range.
  function automatic field_t add_half(input field_t old, input sum_t sum);
    wide_t r;
    r = wide_t'(old) + wide_t'(sum >>> 1);
    if (r > wide_t'(FIELD_MAX)) begin
      add_half = FIELD_MAX;
    end else if (r < wide_t'(FIELD_MIN)) begin
      add_half = FIELD_MIN;
    end else begin
      add_half = field_t'(r);
    end
  endfunction

endpackage

### hdl/fdtd_ram.sv
// Generic simple dual-read, single-write synchronous RAM with registered reads.
// No dependencies.
module fdtd_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hdl/fdtd_calc.sv
// Cell update datapath: computes the new Ez, or the new Hx and Hy, of one cell.
// Depends on fdtd_pkg.
module fdtd_calc (
  input  fdtd_pkg::calc_ctl_t ctl,
  input  fdtd_pkg::field_t    src_level,
  input  fdtd_pkg::cell_t     cur,
  input  fdtd_pkg::field_t    t1,
  input  fdtd_pkg::field_t    t2,
  output fdtd_pkg::cell_t     result
);
  import fdtd_pkg::*;

  sum_t sum_ez;
  sum_t sum_hx;
  sum_t sum_hy;

  assign sum_ez = sum_t'(cur.hy) - sum_t'(t1) - sum_t'(cur.hx) + sum_t'(t2);
  assign sum_hx = sum_t'(cur.ez) - sum_t'(t2);
  assign sum_hy = sum_t'(t1) - sum_t'(cur.ez);

  always_comb begin
    result = cur;
    if (!ctl.h_phase) begin
      if (ctl.src_hit) begin
        result.ez = src_level;
      end else if (ctl.ez_upd) begin
        result.ez = add_half(cur.ez, sum_ez);
      end
    end else begin
      if (ctl.hx_upd) begin
        result.hx = add_half(cur.hx, sum_hx);
      end
      if (ctl.hy_upd) begin
        result.hy = add_half(cur.hy, sum_hy);
      end
    end
  end

endmodule

### hdl/fdtd_2d_tm_step.sv
// Top level of the 2D TM field solver: command FSM, sweep counters and grid RAM.
// Depends on fdtd_pkg, fdtd_ram and fdtd_calc.
//
// After reset the block clears all GRID_X*GRID_Y cells of its grid RAM with
// busy high. A step beat sweeps the grid twice through the RAM, one cell per
// cycle for Ez and row by row over GRID_X+1 positions for Hx and Hy, and its
// result comes after both sweeps; a read beat returns after its RAM read. Each
// result is shown for one cycle with done high and cannot be held off, and busy
// falls as done rises.
module fdtd_2d_tm_step (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  fdtd_pkg::req_t                     req,
  output logic                               done,
  output fdtd_pkg::rsp_t                     rsp,
  input  logic                               cfg_we,
  input  logic [fdtd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [23:0]                        cfg_data
);
  import fdtd_pkg::*;

  state_t          state;
  state_t          state_next;
  logic [XW-1:0]   x_cnt;
  logic [XW-1:0]   x_cnt_next;
  logic [YW-1:0]   y_cnt;
  logic [YW-1:0]   y_cnt_next;
  logic [AW-1:0]   clr_addr;
  logic [AW-1:0]   clr_addr_next;
  logic [XW-1:0]   rd_x;
  logic [YW-1:0]   rd_y;
  logic            rd_ok;
  logic [31:0]     step_count;
  field_t          source_level;
  logic [2:0]      source_x;
  logic [2:0]      source_y;
  logic            src_ok;

  logic            issue;
  logic            issue_h;
  logic            s1_valid;
  logic            s1_h;
  logic [XW-1:0]   s1_x;
  logic [YW-1:0]   s1_y;
  field_t          prev_hy;
  cell_t           p_word;
  field_t          p_ez_dn;

  logic            we;
  logic [AW-1:0]   waddr;
  cell_t           wdata;
  logic [AW-1:0]   ra;
  logic [AW-1:0]   rb;
  logic [XW-1:0]   h_x;
  cell_t           qa;
  cell_t           qb;

  calc_ctl_t       ctl;
  cell_t           cur;
  field_t          t1;
  field_t          t2;
  cell_t           upd;

  fdtd_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (CELLS)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (ra),
    .rdata_a (qa),
    .raddr_b (rb),
    .rdata_b (qb)
  );

  fdtd_calc u_calc (
    .ctl       (ctl),
    .src_level (source_level),
    .cur       (cur),
    .t1        (t1),
    .t2        (t2),
    .result    (upd)
  );

  assign busy   = (state != ST_IDLE);
  assign src_ok = (int'(source_x) < GRID_X) && (int'(source_y) < GRID_Y);
  assign h_x    = (x_cnt == XW'(GRID_X)) ? '0 : x_cnt;

  always_comb begin
    state_next    = state;
    x_cnt_next    = x_cnt;
    y_cnt_next    = y_cnt;
    clr_addr_next = clr_addr;
    issue         = 1'b0;
    issue_h       = 1'b0;
    ra            = cell_addr(rd_x, rd_y);
    rb            = ra;
    case (state)
      ST_CLEAR: begin
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          x_cnt_next = '0;
          y_cnt_next = '0;
          state_next = (req.cmd == CMD_STEP) ? ST_EZ : ST_READ;
        end
      end
      ST_EZ: begin
        issue = 1'b1;
        ra    = cell_addr(x_cnt, y_cnt);
        rb    = cell_addr(x_cnt, (y_cnt == '0) ? y_cnt : y_cnt - YW'(1));
        if (x_cnt == XW'(GRID_X - 1)) begin
          x_cnt_next = '0;
          if (y_cnt == YW'(GRID_Y - 1)) begin
            y_cnt_next = '0;
            state_next = ST_H;
          end else begin
            y_cnt_next = y_cnt + YW'(1);
          end
        end else begin
          x_cnt_next = x_cnt + XW'(1);
        end
      end
      ST_H: begin
        issue   = 1'b1;
        issue_h = 1'b1;
        ra      = cell_addr(h_x, y_cnt);
        rb      = cell_addr(h_x, (y_cnt == YW'(GRID_Y - 1)) ? y_cnt : y_cnt + YW'(1));
        if (x_cnt == XW'(GRID_X)) begin
          x_cnt_next = '0;
          if (y_cnt == YW'(GRID_Y - 1)) begin
            y_cnt_next = '0;
            state_next = ST_STEPOUT;
          end else begin
            y_cnt_next = y_cnt + YW'(1);
          end
        end else begin
          x_cnt_next = x_cnt + XW'(1);
        end
      end
      ST_READ: begin
        state_next = ST_RDOUT;
      end
      ST_RDOUT: begin
        state_next = ST_IDLE;
      end
      ST_STEPOUT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl.h_phase = s1_h;
    ctl.ez_upd  = (s1_x != '0) && (s1_y != '0);
    ctl.src_hit = src_ok && (s1_x == XW'(source_x)) && (s1_y == YW'(source_y));
    ctl.hx_upd  = (s1_y != YW'(GRID_Y - 1));
    ctl.hy_upd  = (s1_x != XW'(GRID_X));
    if (s1_h) begin
      cur = p_word;
      t1  = qa.ez;
      t2  = p_ez_dn;
    end else begin
      cur = qa;
      t1  = prev_hy;
      t2  = qb.hx;
    end
    if (state == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else begin
      we    = s1_valid && (!s1_h || (s1_x != '0));
      waddr = s1_h ? cell_addr(s1_x - XW'(1), s1_y) : cell_addr(s1_x, s1_y);
      wdata = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      x_cnt      <= '0;
      y_cnt      <= '0;
      clr_addr   <= '0;
      s1_valid   <= 1'b0;
      step_count <= '0;
      done       <= 1'b0;
    end else begin
      state    <= state_next;
      x_cnt    <= x_cnt_next;
      y_cnt    <= y_cnt_next;
      clr_addr <= clr_addr_next;
      s1_valid <= issue;
      done     <= (state == ST_RDOUT) || (state == ST_STEPOUT);
      if (state == ST_STEPOUT) begin
        step_count <= step_count + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_level <= SOURCE_LEVEL_RST;
      source_x     <= SOURCE_X_RST;
      source_y     <= SOURCE_Y_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE_LEVEL: source_level <= cfg_data;
        CFG_SOURCE_X:     source_x     <= cfg_data[2:0];
        CFG_SOURCE_Y:     source_y     <= cfg_data[2:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s1_h <= issue_h;
    s1_x <= x_cnt;
    s1_y <= y_cnt;
    if (s1_valid && !s1_h) begin
      prev_hy <= qa.hy;
    end
    if (s1_valid && s1_h) begin
      p_word  <= qa;
      p_ez_dn <= qb.ez;
    end
    if ((state == ST_IDLE) && start) begin
      rd_x  <= XW'(req.cell_x);
      rd_y  <= YW'(req.cell_y);
      rd_ok <= (int'(req.cell_x) < GRID_X) && (int'(req.cell_y) < GRID_Y);
    end
    if (state == ST_RDOUT) begin
      rsp.ez_value    <= rd_ok ? qa.ez : '0;
      rsp.hx_value    <= rd_ok ? qa.hx : '0;
      rsp.hy_value    <= rd_ok ? qa.hy : '0;
      rsp.steps_taken <= step_count;
    end else if (state == ST_STEPOUT) begin
      rsp.ez_value    <= '0;
      rsp.hx_value    <= '0;
      rsp.hy_value    <= '0;
      rsp.steps_taken <= step_count + 32'd1;
    end
  end

endmodule

### hdl/fdtd_chk.sv
// Port-level checker for the grid solver and its bind to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module fdtd_chk (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `ASSERT_NEXT(a_rst_quiet, clk, 1'b0, rst, !done)
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMPL(a_done_idle, clk, rst, done, !busy)
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done)

endmodule

bind fdtd_2d_tm_step fdtd_chk u_fdtd_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

### tb/fdtd_2d_tm_step_checker.sv
// Checker for the 2D TM field solver: watches the command, result and register ports,
// keeps its own copy of the Ez/Hx/Hy grids to predict every result beat and compares.
// Depends on fdtd_pkg for the beat types, field limits and register indexes.
module fdtd_2d_tm_step_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  fdtd_pkg::req_t                 req,
  input  logic                           done,
  input  fdtd_pkg::rsp_t                 rsp,
  input  logic                           cfg_we,
  input  logic [fdtd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]                    cfg_data,
  output int                             errors,
  output int                             outstanding,
  output int                             checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import fdtd_pkg::*;

  field_t      ez_cells [GRID_X][GRID_Y];
  field_t      hx_cells [GRID_X][GRID_Y];
  field_t      hy_cells [GRID_X][GRID_Y];
  logic [31:0] step_total;
  field_t      src_level;
  logic [2:0]  src_x;
  logic [2:0]  src_y;
  rsp_t        due_readings [$];
  int          err_count = 0;
  int          match_count = 0;

  function automatic field_t nudge(field_t old, int diff);
    longint total;
    total = longint'(old) + longint'(diff >>> 1);
    if (total > longint'(FIELD_MAX)) begin
      return FIELD_MAX;
    end else if (total < longint'(FIELD_MIN)) begin
      return FIELD_MIN;
    end
    return field_t'(total);
  endfunction

  function automatic void advance_grid();
    for (int y = 1; y < GRID_Y; y++) begin
      for (int x = 1; x < GRID_X; x++) begin
        ez_cells[x][y] = nudge(ez_cells[x][y],
          int'(hy_cells[x][y]) - int'(hy_cells[x-1][y])
          - int'(hx_cells[x][y]) + int'(hx_cells[x][y-1]));
      end
    end
    if (int'(src_x) < GRID_X && int'(src_y) < GRID_Y) begin
      ez_cells[src_x][src_y] = src_level;
    end
    for (int y = 0; y < GRID_Y - 1; y++) begin
      for (int x = 0; x < GRID_X; x++) begin
        hx_cells[x][y] = nudge(hx_cells[x][y], int'(ez_cells[x][y]) - int'(ez_cells[x][y+1]));
      end
    end
    for (int y = 0; y < GRID_Y; y++) begin
      for (int x = 0; x < GRID_X - 1; x++) begin
        hy_cells[x][y] = nudge(hy_cells[x][y], int'(ez_cells[x+1][y]) - int'(ez_cells[x][y]));
      end
    end
    step_total = step_total + 32'd1;
  endfunction

  function automatic rsp_t run_command(req_t cmd_beat);
    rsp_t reading;
    reading = '0;
    if (cmd_beat.cmd == CMD_STEP) begin
      advance_grid();
    end else if (int'(cmd_beat.cell_x) < GRID_X && int'(cmd_beat.cell_y) < GRID_Y) begin
      reading.ez_value = ez_cells[cmd_beat.cell_x][cmd_beat.cell_y];
      reading.hx_value = hx_cells[cmd_beat.cell_x][cmd_beat.cell_y];
      reading.hy_value = hy_cells[cmd_beat.cell_x][cmd_beat.cell_y];
    end
    reading.steps_taken = step_total;
    return reading;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int x = 0; x < GRID_X; x++) begin
        for (int y = 0; y < GRID_Y; y++) begin
          ez_cells[x][y] = '0;
          hx_cells[x][y] = '0;
          hy_cells[x][y] = '0;
        end
      end
      step_total = '0;
      src_level  = SOURCE_LEVEL_RST;
      src_x      = SOURCE_X_RST;
      src_y      = SOURCE_Y_RST;
      due_readings.delete();
    end else begin
      if (done) begin
        if (due_readings.size() == 0) begin
          $error("result beat with no command waiting");
          err_count++;
        end else begin
          want = due_readings.pop_front();
          match_count++;
          if (rsp.ez_value !== want.ez_value) begin
            $error("ez_value: expected %0d, got %0d", want.ez_value, rsp.ez_value);
            err_count++;
          end
          if (rsp.hx_value !== want.hx_value) begin
            $error("hx_value: expected %0d, got %0d", want.hx_value, rsp.hx_value);
            err_count++;
          end
          if (rsp.hy_value !== want.hy_value) begin
            $error("hy_value: expected %0d, got %0d", want.hy_value, rsp.hy_value);
            err_count++;
          end
          if (rsp.steps_taken !== want.steps_taken) begin
            $error("steps_taken: expected %0d, got %0d", want.steps_taken, rsp.steps_taken);
            err_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SOURCE_LEVEL: src_level = field_t'(cfg_data);
          CFG_SOURCE_X:     src_x     = cfg_data[2:0];
          CFG_SOURCE_Y:     src_y     = cfg_data[2:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        due_readings.push_back(run_command(req));
      end
    end
    errors      <= err_count;
    outstanding <= due_readings.size();
    checked     <= match_count;
  end

endmodule

### tb/fdtd_2d_tm_step_tb.sv
// Testbench top for the 2D TM field solver: clock, reset, directed and random step
// and read commands, source register settings, and the verdict.
// Depends on fdtd_pkg, fdtd_2d_tm_step and fdtd_2d_tm_step_checker.
module fdtd_2d_tm_step_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fdtd_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  req_t                 req = '0;
  logic                 done;
  rsp_t                 rsp;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [23:0]          cfg_data = '0;
  int                   errors;
  int                   outstanding;
  int                   checked;
  int                   steps_sent = 0;
  int                   reads_sent = 0;
  int                   settings_used = 0;

  fdtd_2d_tm_step dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fdtd_2d_tm_step_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding), .checked(checked)
  );

  always #5 clk = ~clk;

  initial begin
    #15_000_000;
    $display("** fdtd_2d_tm_step: FAILED **");
    $finish;
  end

  task automatic issue(input logic cmd, input logic [2:0] x, input logic [2:0] y);
    req_t beat;
    beat.cmd    = cmd;
    beat.cell_x = x;
    beat.cell_y = y;
    start = 1'b1;
    req   = beat;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (cmd == CMD_STEP) begin
      steps_sent++;
    end else begin
      reads_sent++;
    end
  endtask

  task automatic pause_sender(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] value);
    start = 1'b0;
    while (outstanding != 0 || busy) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_source(input logic [23:0] level, input logic [2:0] x,
                            input logic [2:0] y);
    write_reg(CFG_SOURCE_LEVEL, level);
    write_reg(CFG_SOURCE_X, {21'd0, x});
    write_reg(CFG_SOURCE_Y, {21'd0, y});
    settings_used++;
  endtask

  function automatic logic [2:0] pick_coord();
    if ($urandom_range(0, 3) == 0) begin
      return $urandom_range(0, 1) ? 3'd7 : 3'd0;
    end
    return 3'($urandom_range(0, 7));
  endfunction

  initial begin
    logic [23:0] level;
    int          burst_left;
    int          count;
    bit          steady;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    while (busy) @(negedge clk);

    issue(CMD_READ, 3'd0, 3'd0);
    issue(CMD_READ, 3'd7, 3'd7);
    issue(CMD_STEP, 3'd7, 3'd7);
    issue(CMD_READ, 3'd4, 3'd4);
    issue(CMD_READ, 3'd3, 3'd4);
    issue(CMD_READ, 3'd4, 3'd3);
    issue(CMD_READ, 3'd7, 3'd0);
    issue(CMD_READ, 3'd0, 3'd7);
    set_source(24'h7FFFFF, 3'd0, 3'd0);
    repeat (3) issue(CMD_STEP, 3'd0, 3'd0);
    issue(CMD_READ, 3'd0, 3'd0);
    issue(CMD_READ, 3'd1, 3'd0);
    issue(CMD_READ, 3'd0, 3'd1);
    set_source(24'h800000, 3'd7, 3'd7);
    repeat (3) issue(CMD_STEP, 3'd5, 3'd2);
    issue(CMD_READ, 3'd7, 3'd7);
    issue(CMD_READ, 3'd6, 3'd7);
    issue(CMD_READ, 3'd7, 3'd6);
    issue(CMD_READ, 3'd6, 3'd6);

    while (steps_sent + reads_sent < 1750) begin
      case ($urandom_range(0, 5))
        0:       level = 24'h7FFFFF;
        1:       level = 24'h800000;
        2:       level = 24'h000000;
        default: level = 24'($urandom);
      endcase
      set_source(level, pick_coord(), pick_coord());
      count      = $urandom_range(40, 120);
      steady     = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 12);
      for (int i = 0; i < count; i++) begin
        issue(($urandom_range(0, 9) < 3) ? CMD_STEP : CMD_READ,
              3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
        if (!steady && --burst_left == 0) begin
          pause_sender($urandom_range(1, 6));
          burst_left = $urandom_range(1, 12);
        end
      end
    end

    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    $display("Sent %0d steps and %0d reads under %0d source settings; %0d results checked.",
             steps_sent, reads_sent, settings_used, checked);
    if (errors == 0) begin
      $display("** fdtd_2d_tm_step: PASSED **");
    end else begin
      $display("** fdtd_2d_tm_step: FAILED **");
    end
    $finish;
  end

endmodule
